// ===== rtl/ssq_pkg.sv =====
// Shared types, constants and phase tables for the stepper phase sequencer.
`default_nettype none

package ssq_pkg;

    // Divider widths: dividend holds the tick rate or max_speed, divisor holds a speed or the full scale
    localparam int DVD_W = 17;
    localparam int DVS_W = 16;
    localparam int CNT_W = 5;

    localparam logic [DVD_W-1:0] TICK_RATE = 17'd100000;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_SPEED = 2'd0;
    localparam logic [1:0] CFG_MIN_SPEED = 2'd1;
    localparam logic [1:0] CFG_STOP_THR  = 2'd2;

    // Drive modes
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_DUAL   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN_START,
        ST_GAIN_WAIT,
        ST_MUL,
        ST_SAT,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_UPDATE
    } ssq_state_t;

    typedef struct packed {
        logic capture;    // latch the input item
        logic div_start;  // launch the divider
        logic div_rate;   // 1: tick rate / speed, 0: max_speed / full scale
        logic mul;        // product = sample * gain
        logic sat;        // saturate and apply stop threshold
        logic update;     // advance the step timer and load the result
    } ssq_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_full;
    } ssq_status_t;

    // Coil pattern for a phase index in a given table
    function automatic logic [3:0] coil_lookup(logic [1:0] mode, logic [2:0] idx);
        logic [3:0] pat;
        pat = 4'b0000;
        case (mode)
            MODE_SINGLE:
            begin
                case (idx[1:0])
                    2'd0:    pat = 4'b0001;
                    2'd1:    pat = 4'b0010;
                    2'd2:    pat = 4'b0100;
                    default: pat = 4'b1000;
                endcase
            end
            MODE_DUAL:
            begin
                case (idx[1:0])
                    2'd0:    pat = 4'b0011;
                    2'd1:    pat = 4'b0110;
                    2'd2:    pat = 4'b1100;
                    default: pat = 4'b1001;
                endcase
            end
            MODE_HALF:
            begin
                case (idx)
                    3'd0:    pat = 4'b0001;
                    3'd1:    pat = 4'b0011;
                    3'd2:    pat = 4'b0010;
                    3'd3:    pat = 4'b0110;
                    3'd4:    pat = 4'b0100;
                    3'd5:    pat = 4'b1100;
                    3'd6:    pat = 4'b1000;
                    default: pat = 4'b1001;
                endcase
            end
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

    // Next phase index; an index left beyond a short table wraps to its end
    // when reversing and to zero when going forward.
    function automatic logic [2:0] phase_next(logic [1:0] mode, logic fwd,
                                              logic [2:0] idx);
        logic [2:0] last;
        logic       beyond;
        logic [2:0] nxt;
        last   = (mode == MODE_HALF) ? 3'd7 : 3'd3;
        beyond = (mode != MODE_HALF) && (idx > 3'd4);
        if (fwd)
            nxt = (idx >= last) ? 3'd0 : idx + 3'd1;
        else
            nxt = ((idx == 3'd0) || beyond) ? last : idx - 3'd1;
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssq_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module ssq_div
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [ssq_pkg::DVD_W-1:0]   dividend,
    input  wire  [ssq_pkg::DVS_W-1:0]   divisor,
    output logic [ssq_pkg::DVD_W-1:0]   quotient,
    output logic                        done
);
    import ssq_pkg::*;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    // One shift-subtract step
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next  = {dvd_reg[DVD_W-2:0], ge};
            rem_next  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== rtl/ssq_ctrl.sv =====
// Sequencing state machine for one tick.
`default_nettype none

module ssq_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  ssq_pkg::ssq_status_t  status,
    output ssq_pkg::ssq_cmd_t     cmd
);
    import ssq_pkg::*;

    ssq_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_GAIN_START;
                end
            end
            ST_GAIN_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_GAIN_WAIT;
            end
            ST_GAIN_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_RATE_START;
            end
            ST_RATE_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_rate  = 1'b1;
                state_next    = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                cmd.div_rate = 1'b1;
                if (status.div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!status.out_full)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ssq_datapath.sv =====
// Configuration, speed scaling, step timer, phase state and result register.
`default_nettype none

module ssq_datapath
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  ssq_pkg::ssq_cmd_t      cmd,
    output ssq_pkg::ssq_status_t   status,
    input  wire                    cfg_write,
    input  wire  [1:0]             cfg_index,
    input  wire  [15:0]            cfg_data,
    input  wire  [SAMPLE_BITS-1:0] speed_sample,
    input  wire                    direction,
    input  wire  [1:0]             mode_select,
    output logic [3:0]             coil_drive,
    output logic                   stepped,
    output logic                   out_valid,
    input  wire                    out_ready
);
    import ssq_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + DVS_W;
    localparam logic [DVS_W-1:0] FULL_SCALE = DVS_W'((1 << SAMPLE_BITS) - 1);

    logic [15:0] max_speed_reg, min_speed_reg, stop_thr_reg;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   dir_reg;
    logic [1:0]             mode_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [DVS_W-1:0]       speed_reg;
    logic                   stop_reg;

    logic [DVD_W-1:0] elapsed_reg, elapsed_next;
    logic [2:0]       phase_reg, phase_next_v;
    logic [3:0]       coil_reg, coil_next;
    logic             fire;
    logic [1:0]       mode_eff;

    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DVD_W-1:0] div_q;
    logic             div_done;

    logic [DVS_W-1:0] speed_sat;
    logic [DVS_W-1:0] speed_sel;
    logic             below;

    logic       out_valid_reg;
    logic [3:0] out_coil_reg;
    logic       out_step_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= 16'd10000;
            min_speed_reg <= 16'd1;
            stop_thr_reg  <= 16'd100;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                CFG_MIN_SPEED: min_speed_reg <= cfg_data;
                CFG_STOP_THR:  stop_thr_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Shared divider: gain first, then the step interval
    assign div_dividend = cmd.div_rate ? TICK_RATE : {1'b0, max_speed_reg};
    assign div_divisor  = cmd.div_rate ? speed_reg : FULL_SCALE;

    ssq_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    // Saturation, stop threshold and zero guard
    always_comb
    begin
        speed_sat = (|prod_reg[PROD_W-1:DVS_W]) ? '1 : prod_reg[DVS_W-1:0];
        below     = (speed_sat <= stop_thr_reg);
        speed_sel = below ? min_speed_reg : speed_sat;
        if (speed_sel == '0)
            speed_sel = DVS_W'(1);
    end

    // Item capture, product and speed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= speed_sample;
            dir_reg    <= direction;
            mode_reg   <= mode_select;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(sample_reg) * PROD_W'(div_q[DVS_W-1:0]);
        if (cmd.sat)
        begin
            speed_reg <= speed_sel;
            stop_reg  <= below;
        end
    end

    // Step timer and phase advance
    always_comb
    begin
        mode_eff     = stop_reg ? MODE_STOP : mode_reg;
        elapsed_next = elapsed_reg + DVD_W'(1);
        fire         = (elapsed_next >= div_q);
        phase_next_v = phase_reg;
        coil_next    = coil_reg;
        if (fire)
        begin
            elapsed_next = '0;
            if (mode_eff == MODE_STOP)
                coil_next = 4'b0000;
            else
            begin
                phase_next_v = phase_next(mode_eff, dir_reg, phase_reg);
                coil_next    = coil_lookup(mode_eff, phase_next_v);
            end
        end
    end

    // Motor state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            phase_reg     <= '0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                elapsed_reg   <= elapsed_next;
                phase_reg     <= phase_next_v;
                coil_reg      <= coil_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_coil_reg <= coil_next;
            out_step_reg <= fire;
        end
    end

    assign status.div_done = div_done;
    assign status.out_full = out_valid_reg;
    assign coil_drive      = out_coil_reg;
    assign stepped         = out_step_reg;
    assign out_valid       = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/stepper_phase_sequencer.sv =====
// Top level of the stepper phase sequencer.
//
//  channel | direction | signals                         | payload
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser | speed_sample, direction; mode_select
//  m_*     | out       | m_tvalid m_tready m_tdata m_tuser | coil_drive; stepped
//  cfg_*   | in        | cfg_valid cfg_ready cfg_index cfg_data | register index, value
//
// A tick runs from input transfer to a valid result through two passes of
// the shared restoring divider (start, 17 shift-subtract steps, done), plus
// the multiply, saturate and update steps. The next tick is taken the cycle
// after the update step; no new input is taken while a tick is in progress.
// A result waiting on m_tready stalls only the update step.
// Reset is asynchronous; no clearing pass.
`default_nettype none

module stepper_phase_sequencer
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [((SAMPLE_BITS+8)/8)*8-1:0] s_tdata,  // speed_sample, direction
    input  wire  [1:0]                       s_tuser,  // mode_select
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,  // coil_drive
    output logic                             m_tuser,  // stepped
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [1:0]                       cfg_index,
    input  wire  [15:0]                      cfg_data
);
    import ssq_pkg::*;

    ssq_cmd_t    cmd;
    ssq_status_t status;
    logic [3:0]  coil_drive;

    ssq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssq_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .speed_sample (s_tdata[SAMPLE_BITS-1:0]),
        .direction    (s_tdata[SAMPLE_BITS]),
        .mode_select  (s_tuser),
        .coil_drive   (coil_drive),
        .stepped      (m_tuser),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

    assign m_tdata   = {4'b0000, coil_drive};
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/ssq_checker.sv =====
// Port-level checks for the stepper phase sequencer, bound to the top level.
`default_nettype none

module ssq_checker
(
    input wire       clk,
    input wire       rst_n,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One tick at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a tick is in progress");

    // Coils are off, one phase or two phases on, and the upper bits of m_tdata are zero
    a_coil_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(m_tdata[3:0]) <= 2) && (m_tdata[7:4] == 4'b0000))
        else $error("illegal coil pattern");

endmodule

bind stepper_phase_sequencer ssq_checker u_ssq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
